[rtl/cisf_pkg.sv]
// Package for the case-insensitive substring finder.
// Shared constants, register codes, the case-fold function and the cell control struct.
// No dependencies.
`default_nettype none

package cisf_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int INDEX_BITS_DEF  = 16;

  // pattern register is a fixed 8-byte word
  localparam int PAT_BYTES     = 8;
  localparam int PAT_IDX_BITS  = 3;
  localparam int LEN_BITS      = 4;
  localparam int APB_DATA_BITS = 64;
  localparam int APB_ADDR_BITS = 4;
  localparam int MATCH_IDX_BITS = 16;

  localparam logic [7:0] TERMINATOR = 8'h00;

  // register index, taken from paddr[3]
  typedef enum logic {
    REG_PATTERN_BYTES  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic shift;  // take a new byte into the window
    logic clear;  // end of string, flush the window
  } cell_ctrl_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/case_insensitive_substring_find_unit.sv]
// Top level of the case-insensitive substring finder.
// Instantiates cisf_regs and a row of cisf_cell; depends on cisf_pkg.
//
// Usage:
//   s_* stream carries the searched string, one byte per request, ending with
//   a zero byte. Letters a-z are folded to upper case before comparison.
//   m_* stream carries one result per string, emitted for the terminator.
//   The APB port holds the pattern (address 0, 64 bits) and its length
//   (address 8, 4 bits). Write them only while the block is idle.
// Throughput: one text byte per cycle unless a result waits untaken; the window
//   shift and the parallel compare of all cells finish in the cycle the byte is accepted.
// Latency: the result is valid in m_tdata the cycle after the terminator
//   is accepted.
// Stall: the result sits in an output register; while it waits untaken,
//   s_tready is low for every text byte. It rises again in the cycle that
//   m_tready is seen, so the next byte is taken in that same cycle.
// Reset (rst, synchronous): registers, window, counters and the output
//   register clear; the pattern reads as empty.
// Overflow: the byte count saturates at 2^INDEX_BITS-1; further bytes set
//   the overflow flag and cannot start a new match.
`default_nettype none

module case_insensitive_substring_find_unit #(
  parameter int PATTERN_MAX = cisf_pkg::PATTERN_MAX_DEF,
  parameter int INDEX_BITS  = cisf_pkg::INDEX_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // APB configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [cisf_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [cisf_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [cisf_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                     pready,
  // text in
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [7:0]                          s_tdata,  // [7:0] text_byte
  // result out
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [23:0]                         m_tdata   // [0] found, [16:1] match_index,
                                                             // [17] overflow, [23:18] zero
);
  import cisf_pkg::*;

  localparam logic [INDEX_BITS-1:0] COUNT_MAX = '1;

  logic [LEN_BITS-1:0] eff_len;
  logic [7:0]          cell_pat  [PATTERN_MAX];
  logic                cell_used [PATTERN_MAX];
  logic [7:0]          cell_din  [PATTERN_MAX];
  logic [7:0]          cell_dout [PATTERN_MAX];
  logic                cell_hit  [PATTERN_MAX];
  cell_ctrl_t          ctrl;

  logic                  in_accept;
  logic                  is_term;
  logic                  window_hit;
  logic                  counted;
  logic                  record;
  logic [INDEX_BITS-1:0] count_inc;
  logic [INDEX_BITS-1:0] len_ext;

  // search state
  logic [INDEX_BITS-1:0] position_count;
  logic                  match_seen;
  logic [INDEX_BITS-1:0] first_match_index;
  logic                  count_saturated;

  // result register
  logic                        res_found;
  logic [MATCH_IDX_BITS-1:0]   res_index;
  logic                        res_overflow;
  logic [INDEX_BITS+MATCH_IDX_BITS-1:0] idx_wide;

  cisf_regs #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .eff_len   (eff_len),
    .cell_pat  (cell_pat),
    .cell_used (cell_used)
  );

  // handshake: output register frees up in the same cycle it is taken
  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign is_term   = (s_tdata == TERMINATOR);

  assign ctrl.shift = in_accept && !is_term;
  assign ctrl.clear = in_accept && is_term;

  // the window: cell 0 takes the new folded byte, each cell feeds the next
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_din[k] = fold_upper(s_tdata);
    end else begin : g_body
      assign cell_din[k] = cell_dout[k-1];
    end

    cisf_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .din  (cell_din[k]),
      .pat  (cell_pat[k]),
      .used (cell_used[k]),
      .dout (cell_dout[k]),
      .hit  (cell_hit[k])
    );
  end

  always_comb begin
    window_hit = 1'b1;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      window_hit = window_hit && cell_hit[k];
    end
  end

  assign counted   = (position_count != COUNT_MAX);
  assign count_inc = position_count + INDEX_BITS'(1);
  assign len_ext   = INDEX_BITS'(eff_len);
  // a match is only recorded on a counted byte, once enough bytes are in
  assign record    = counted && !match_seen && (eff_len != '0) &&
                     (count_inc >= len_ext) && window_hit;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      position_count    <= '0;
      match_seen        <= 1'b0;
      first_match_index <= '0;
      count_saturated   <= 1'b0;
    end else if (ctrl.shift) begin
      if (counted) begin
        position_count <= count_inc;
      end else begin
        count_saturated <= 1'b1;
      end
      if (record) begin
        match_seen        <= 1'b1;
        first_match_index <= count_inc - len_ext;
      end
    end
  end

  // index as 16 bits: truncate a wider count, zero-extend a narrower one
  assign idx_wide = {{MATCH_IDX_BITS{1'b0}}, first_match_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.clear) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_found    <= 1'b0;
      res_index    <= '0;
      res_overflow <= 1'b0;
    end else if (ctrl.clear) begin
      if (eff_len == '0) begin
        res_found <= 1'b1;
        res_index <= '0;
      end else begin
        res_found <= match_seen;
        res_index <= match_seen ? idx_wide[MATCH_IDX_BITS-1:0] : '0;
      end
      res_overflow <= count_saturated;
    end
  end

  assign m_tdata = {6'b0, res_overflow, res_index, res_found};

  // ---------------------------------------------------------------- checks
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> (m_tvalid && position_count == '0 && !match_seen && !count_saturated))
    else $error("terminator did not load result and clear search state");

  a_sat_at_max: assert property (@(posedge clk) disable iff (rst)
    count_saturated |-> (position_count == COUNT_MAX))
    else $error("overflow flagged below saturated count");

  a_match_before_count: assert property (@(posedge clk) disable iff (rst)
    match_seen |-> (first_match_index < position_count))
    else $error("recorded match index not behind the byte count");

  a_no_new_match_saturated: assert property (@(posedge clk) disable iff (rst)
    (ctrl.shift && !counted && !match_seen) |=> !match_seen)
    else $error("match recorded on an uncounted byte");

endmodule

`default_nettype wire

[rtl/cisf_regs.sv]
// Configuration registers of the substring finder on an APB-style port.
// Derives the effective pattern length and the per-cell aligned pattern bytes.
// Depends on cisf_pkg.
`default_nettype none

module cisf_regs #(
  parameter int PATTERN_MAX = cisf_pkg::PATTERN_MAX_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [cisf_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [cisf_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [cisf_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                     pready,
  output logic      [cisf_pkg::LEN_BITS-1:0]       eff_len,
  output logic      [7:0]                          cell_pat [PATTERN_MAX],
  output logic                                     cell_used [PATTERN_MAX]
);
  import cisf_pkg::*;

  logic [APB_DATA_BITS-1:0] pattern_bytes;
  logic [LEN_BITS-1:0]      pattern_length;
  logic [7:0]               pat_folded [PAT_BYTES];
  logic [LEN_BITS-1:0]      len_clamped;
  logic                     wr_en;
  reg_idx_t                 reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_idx_t'(paddr[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PATTERN_BYTES:  pattern_bytes  <= pwdata;
        REG_PATTERN_LENGTH: pattern_length <= pwdata[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_BYTES:  prdata = pattern_bytes;
      REG_PATTERN_LENGTH: prdata = {{(APB_DATA_BITS-LEN_BITS){1'b0}}, pattern_length};
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    for (int j = 0; j < PAT_BYTES; j++) begin
      pat_folded[j] = fold_upper(pattern_bytes[8*j +: 8]);
    end
  end

  // clamp, then cut at the first zero byte inside the length
  always_comb begin
    len_clamped = (pattern_length > LEN_BITS'(PATTERN_MAX)) ? LEN_BITS'(PATTERN_MAX)
                                                            : pattern_length;
    eff_len = len_clamped;
    for (int j = PATTERN_MAX - 1; j >= 0; j--) begin
      if (LEN_BITS'(j) < len_clamped && pat_folded[j] == 8'h00) begin
        eff_len = LEN_BITS'(j);
      end
    end
  end

  // cell k compares the byte k places back; it must equal pattern byte len-1-k
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      cell_used[k] = LEN_BITS'(k) < eff_len;
      cell_pat[k]  = pat_folded[PAT_IDX_BITS'(eff_len - LEN_BITS'(k) - LEN_BITS'(1))];
    end
  end

endmodule

`default_nettype wire

[rtl/cisf_cell.sv]
// One window cell: holds a folded text byte, passes it on, compares the incoming byte.
// Depends on cisf_pkg.
`default_nettype none

module cisf_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cisf_pkg::cell_ctrl_t ctrl,
  input  wire logic [7:0]           din,
  input  wire logic [7:0]           pat,
  input  wire logic                 used,
  output logic      [7:0]           dout,
  output logic                      hit
);
  import cisf_pkg::*;

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      held <= '0;
    end else if (ctrl.shift) begin
      held <= din;
    end
  end

  assign dout = held;
  // compare against the byte this cell is about to take
  assign hit  = !used || (din == pat);

endmodule

`default_nettype wire
